>>> rtl/core/i2c_memory_master_unit_defines.svh
// ----------------------------------------------------------------------------
// i2c memory master assertion macros
// shared assertion forms for the serial memory master, clocked on clk and
// held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef I2C_MEMORY_MASTER_UNIT_DEFINES_SVH
`define I2C_MEMORY_MASTER_UNIT_DEFINES_SVH

// same-cycle implication
`define I2CMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c memory master check failed");

// next-cycle implication
`define I2CMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c memory master check failed");

`endif

>>> rtl/core/i2cmm_pkg.sv
// ----------------------------------------------------------------------------
// i2cmm_pkg
// types and constants of the i2c serial memory master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmm_pkg;

    // byte counter width
    localparam int CountWidth = 16;

    // control byte parts
    localparam logic [7:0] CTRL_BASE = 8'hA0;
    localparam logic [7:0] READ_BIT  = 8'h01;

    // reset values of the timing registers
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
    localparam logic [7:0] HOLD_TICKS_RST  = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS  = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    // command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_DATA  = 2'd3
    } cmd_t;

    // bus sequencer phases
    typedef enum logic [3:0] {
        P_IDLE        = 4'd0,
        P_START_SETUP = 4'd1,
        P_START_HOLD  = 4'd2,
        P_TX_SETUP    = 4'd3,
        P_TX_HIGH     = 4'd4,
        P_TX_AFTER    = 4'd5,
        P_ACK_POLL    = 4'd6,
        P_ACK_HOLD    = 4'd7,
        P_WAIT_BYTE   = 4'd8,
        P_RX_SETUP    = 4'd9,
        P_RX_LOW      = 4'd10,
        P_RX_HIGH     = 4'd11,
        P_MACK_LOW    = 4'd12,
        P_MACK_HIGH   = 4'd13,
        P_STOP_SETUP  = 4'd14,
        P_STOP_HOLD   = 4'd15
    } phase_t;

    // byte being sent
    typedef enum logic [1:0] {
        S_CTRL    = 2'd0,
        S_ADDR    = 2'd1,
        S_CTRL_RD = 2'd2,
        S_DATA    = 2'd3
    } stage_t;

    // one result item
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       need_byte;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       busy_res;
        logic       done_res;
        logic       status;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/i2c_memory_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_memory_master_unit
// i2c master for a serial memory: random read and page write, one bus tick
// per input transaction
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick carrying the sampled SDA level and an
// optional command; each one yields exactly one result transaction with the
// line levels and status after that tick. The block takes one tick per clock
// cycle while in_stall is low; the sequencer update is a single pass of logic
// from the state registers into the state and result registers. A result
// register plus a one-entry skid buffer sit on the output, so in_stall is
// registered and rises only once two results are waiting. Timing registers
// may be rewritten only while the block is idle.
`default_nettype none

`include "i2c_memory_master_unit_defines.svh"

module i2c_memory_master_unit
    import i2cmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [2:0]  page_addr,
    input  wire logic [7:0]  word_addr,
    input  wire logic [15:0] byte_count,
    input  wire logic [7:0]  wr_byte,
    input  wire logic        sda_in,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl,
    output logic             sda_out,
    output logic             sda_drive,
    output logic             need_byte,
    output logic             rd_valid,
    output logic [7:0]       rd_byte,
    output logic             busy_res,
    output logic             done_res,
    output logic             status
);

    // configuration registers
    logic [7:0] phase_ticks_reg;
    logic [7:0] hold_ticks_reg;
    logic [7:0] ack_timeout_reg;

    // sequencer state
    phase_t                phase_reg,      phase_next;
    stage_t                stage_reg,      stage_next;
    logic                  is_read_reg,    is_read_next;
    logic [7:0]            shift_reg,      shift_next;
    logic [3:0]            bit_index_reg,  bit_index_next;
    logic [CountWidth-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]            tick_count_reg, tick_count_next;
    logic [7:0]            poll_count_reg, poll_count_next;
    logic [2:0]            page_latch_reg, page_latch_next;
    logic [7:0]            addr_latch_reg, addr_latch_next;
    logic                  err_flag_reg,   err_flag_next;

    // output buffering
    logic out_valid_reg;
    res_t out_data_reg;
    logic skid_valid_reg;
    res_t skid_data_reg;

    logic       in_accept;
    logic       out_take;
    res_t       res_next;
    logic [7:0] tick_inc;
    logic       hold_done;
    logic       half_done;
    logic [3:0] bit_inc;
    logic       do_next_data;
    logic       rx_done;
    logic       finish;
    logic [7:0] ctrl_byte;
    cmd_t       cmd_in;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign cmd_in    = cmd_t'(cmd);
    assign tick_inc  = tick_count_reg + 8'd1;
    assign hold_done = (tick_inc >= hold_ticks_reg);
    assign half_done = (tick_inc >= phase_ticks_reg);
    assign bit_inc   = bit_index_reg + 4'd1;
    assign ctrl_byte = CTRL_BASE | {4'd0, page_latch_reg, 1'b0};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            hold_ticks_reg  <= HOLD_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                REG_HOLD_TICKS:  hold_ticks_reg  <= cfg_data;
                REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        is_read_next    = is_read_reg;
        shift_next      = shift_reg;
        bit_index_next  = bit_index_reg;
        bytes_left_next = bytes_left_reg;
        tick_count_next = tick_count_reg;
        poll_count_next = poll_count_reg;
        page_latch_next = page_latch_reg;
        addr_latch_next = addr_latch_reg;
        err_flag_next   = err_flag_reg;
        do_next_data    = 1'b0;
        rx_done         = 1'b0;
        finish          = 1'b0;

        unique case (phase_reg)
            P_IDLE:
            begin
                if (cmd_in == CMD_WRITE || cmd_in == CMD_READ)
                begin
                    is_read_next    = (cmd_in == CMD_READ);
                    page_latch_next = page_addr;
                    addr_latch_next = word_addr;
                    bytes_left_next = byte_count[CountWidth-1:0];
                    stage_next      = S_CTRL;
                    err_flag_next   = 1'b0;
                    poll_count_next = 8'd0;
                    bit_index_next  = 4'd0;
                    phase_next      = P_START_SETUP;
                    tick_count_next = 8'd0;
                end
            end
            P_START_SETUP:
            begin
                tick_count_next = tick_inc;
                if (hold_done)
                begin
                    phase_next      = P_START_HOLD;
                    tick_count_next = 8'd0;
                end
            end
            P_START_HOLD:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    shift_next      = (stage_reg == S_CTRL_RD) ? (ctrl_byte | READ_BIT)
                                                               : ctrl_byte;
                    bit_index_next  = 4'd0;
                    phase_next      = P_TX_SETUP;
                    tick_count_next = 8'd0;
                end
            end
            P_TX_SETUP:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    phase_next      = P_TX_HIGH;
                    tick_count_next = 8'd0;
                end
            end
            P_TX_HIGH:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    phase_next      = P_TX_AFTER;
                    tick_count_next = 8'd0;
                end
            end
            P_TX_AFTER:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    bit_index_next  = bit_inc;
                    tick_count_next = 8'd0;
                    if (bit_inc >= 4'd8)
                    begin
                        poll_count_next = 8'd0;
                        phase_next      = P_ACK_POLL;
                    end
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = P_TX_SETUP;
                    end
                end
            end
            P_ACK_POLL:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    tick_count_next = 8'd0;
                    if (!sda_in)
                    begin
                        phase_next = P_ACK_HOLD;
                    end
                    else if (poll_count_reg >= ack_timeout_reg)
                    begin
                        err_flag_next = 1'b1;
                        phase_next    = P_STOP_SETUP;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 8'd1;
                    end
                end
            end
            P_ACK_HOLD:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    tick_count_next = 8'd0;
                    if (stage_reg == S_CTRL)
                    begin
                        stage_next     = S_ADDR;
                        shift_next     = addr_latch_reg;
                        bit_index_next = 4'd0;
                        phase_next     = P_TX_SETUP;
                    end
                    else if (stage_reg == S_ADDR && is_read_reg)
                    begin
                        stage_next = S_CTRL_RD;
                        phase_next = P_START_SETUP;
                    end
                    else
                    begin
                        do_next_data = 1'b1;
                    end
                end
            end
            P_WAIT_BYTE:
            begin
                if (cmd_in == CMD_DATA)
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                    shift_next      = wr_byte;
                    bit_index_next  = 4'd0;
                    phase_next      = P_TX_SETUP;
                    tick_count_next = 8'd0;
                end
            end
            P_RX_SETUP:
            begin
                tick_count_next = tick_inc;
                if (hold_done)
                begin
                    phase_next      = P_RX_LOW;
                    tick_count_next = 8'd0;
                end
            end
            P_RX_LOW:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    shift_next      = {shift_reg[6:0], sda_in};
                    bit_index_next  = bit_inc;
                    phase_next      = P_RX_HIGH;
                    tick_count_next = 8'd0;
                end
            end
            P_RX_HIGH:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    tick_count_next = 8'd0;
                    if (bit_index_reg >= 4'd8)
                    begin
                        rx_done    = 1'b1;
                        phase_next = P_MACK_LOW;
                    end
                    else
                    begin
                        phase_next = P_RX_LOW;
                    end
                end
            end
            P_MACK_LOW:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    phase_next      = P_MACK_HIGH;
                    tick_count_next = 8'd0;
                end
            end
            P_MACK_HIGH:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    tick_count_next = 8'd0;
                    do_next_data    = 1'b1;
                end
            end
            P_STOP_SETUP:
            begin
                tick_count_next = tick_inc;
                if (hold_done)
                begin
                    phase_next      = P_STOP_HOLD;
                    tick_count_next = 8'd0;
                end
            end
            P_STOP_HOLD:
            begin
                tick_count_next = tick_inc;
                if (half_done)
                begin
                    finish          = 1'b1;
                    phase_next      = P_IDLE;
                    tick_count_next = 8'd0;
                end
            end
            default:
            begin
                phase_next      = P_IDLE;
                tick_count_next = 8'd0;
            end
        endcase

        // move on to the data bytes, or stop when none are left
        if (do_next_data)
        begin
            stage_next = S_DATA;
            if (bytes_left_reg == '0)
            begin
                phase_next = P_STOP_SETUP;
            end
            else if (is_read_reg)
            begin
                bytes_left_next = bytes_left_reg - 1'b1;
                bit_index_next  = 4'd0;
                shift_next      = 8'd0;
                phase_next      = P_RX_SETUP;
            end
            else
            begin
                phase_next = P_WAIT_BYTE;
            end
        end
    end

    // line levels and status after this tick
    always_comb
    begin
        res_next           = '0;
        res_next.scl       = 1'b1;
        res_next.sda_out   = 1'b1;
        res_next.sda_drive = 1'b1;

        unique case (phase_next)
            P_START_HOLD:
            begin
                res_next.sda_out = 1'b0;
            end
            P_TX_SETUP, P_TX_AFTER:
            begin
                res_next.scl     = 1'b0;
                res_next.sda_out = shift_next[7];
            end
            P_TX_HIGH:
            begin
                res_next.sda_out = shift_next[7];
            end
            P_ACK_POLL, P_ACK_HOLD, P_RX_HIGH:
            begin
                res_next.sda_drive = 1'b0;
            end
            P_WAIT_BYTE:
            begin
                res_next.scl       = 1'b0;
                res_next.sda_drive = 1'b0;
                res_next.need_byte = 1'b1;
            end
            P_RX_SETUP, P_RX_LOW:
            begin
                res_next.scl       = 1'b0;
                res_next.sda_drive = 1'b0;
            end
            P_MACK_LOW:
            begin
                res_next.scl     = 1'b0;
                res_next.sda_out = (bytes_left_next == '0);
            end
            P_MACK_HIGH:
            begin
                res_next.sda_out = (bytes_left_next == '0);
            end
            P_STOP_SETUP:
            begin
                res_next.scl     = 1'b0;
                res_next.sda_out = 1'b0;
            end
            P_STOP_HOLD:
            begin
                res_next.sda_out = 1'b0;
            end
            default:
            begin
                res_next.scl = 1'b1;
            end
        endcase

        res_next.rd_valid = rx_done;
        res_next.rd_byte  = rx_done ? shift_next : 8'd0;
        res_next.busy_res = (phase_next != P_IDLE);
        res_next.done_res = finish;
        res_next.status   = finish && err_flag_next;
    end

    // sequencer state registers, advanced once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            stage_reg      <= S_CTRL;
            is_read_reg    <= 1'b0;
            shift_reg      <= 8'd0;
            bit_index_reg  <= 4'd0;
            bytes_left_reg <= '0;
            tick_count_reg <= 8'd0;
            poll_count_reg <= 8'd0;
            page_latch_reg <= 3'd0;
            addr_latch_reg <= 8'd0;
            err_flag_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            is_read_reg    <= is_read_next;
            shift_reg      <= shift_next;
            bit_index_reg  <= bit_index_next;
            bytes_left_reg <= bytes_left_next;
            tick_count_reg <= tick_count_next;
            poll_count_reg <= poll_count_next;
            page_latch_reg <= page_latch_next;
            addr_latch_reg <= addr_latch_next;
            err_flag_reg   <= err_flag_next;
        end
    end

    // output valid flags of the result register and skid buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= res_next;
            end
            else
            begin
                out_data_reg <= res_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign scl       = out_data_reg.scl;
    assign sda_out   = out_data_reg.sda_out;
    assign sda_drive = out_data_reg.sda_drive;
    assign need_byte = out_data_reg.need_byte;
    assign rd_valid  = out_data_reg.rd_valid;
    assign rd_byte   = out_data_reg.rd_byte;
    assign busy_res  = out_data_reg.busy_res;
    assign done_res  = out_data_reg.done_res;
    assign status    = out_data_reg.status;

    // checks
    `I2CMM_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `I2CMM_ASSERT_NOW(a_read_ctrl_only_on_read, stage_reg == S_CTRL_RD, is_read_reg)
    `I2CMM_ASSERT_NOW(a_wait_byte_only_on_write, phase_reg == P_WAIT_BYTE, !is_read_reg)
    `I2CMM_ASSERT_NOW(a_bit_index_range, 1'b1, bit_index_reg <= 4'd8)
    `I2CMM_ASSERT_NEXT(a_stalled_result_kept, out_valid_reg && out_stall, out_valid_reg)

endmodule

`default_nettype wire
